@@ design/pcs_pkg.sv @@
// Shared constants and types for the POV column scheduler.
// Used by pcs_timer, pcs_image_mem and pov_column_scheduler; no dependencies.
`default_nettype none

package pcs_pkg;

	// Default build values of the top-level parameters.
	localparam int COLUMNS_DEF    = 120;
	localparam int TICK_WIDTH_DEF = 16;

	// Fixed field widths.
	localparam int MODE_W = 2;
	localparam int ADDR_W = 7;
	localparam int BITS_W = 16;
	localparam int COL_W  = 7;
	localparam int TPC_W  = 10;
	// Column counter: holds 0..COLUMNS, COLUMNS at most 511.
	localparam int CNT_W  = 9;

	localparam logic [TPC_W-1:0] TPC_MAX = {TPC_W{1'b1}};

	// Input word kinds carried on s_tuser.
	localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PULSE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd2;

	// Column position after an item, from the timer to the pipeline.
	typedef struct packed {
		logic             hit;
		logic [CNT_W-1:0] col;
	} pcs_col_t;

endpackage

`default_nettype wire

@@ design/pov_column_scheduler.sv @@
// Top level of the POV column scheduler: input decode, read pipeline, output register.
// Depends on pcs_pkg, pcs_timer and pcs_image_mem.
//
//  channel | dir | tdata (low bit up)                 | tuser
//  --------+-----+------------------------------------+---------------------
//  s_*     | in  | column_addr[6:0], column_bits[22:7] | mode[1:0]
//  m_*     | out | column[6:0], pattern[22:7]          | pattern_valid[0]
//
// One input word per cycle while s_tready is high, with no bubbles. A tick or pulse
// word shows its result after the registered read of the column image memory
// (stage 1) and then the output register.
// Reset zeroes the counters and clears the per-column valid bits at once, so
// the image reads blank with no clearing pass. Image writes and mode 3 give no word.
// With m_tready low the output word holds and one more result waits in stage 1;
// only then does s_tready drop.
`default_nettype none

module pov_column_scheduler #(
	parameter int COLUMNS    = pcs_pkg::COLUMNS_DEF,
	parameter int TICK_WIDTH = pcs_pkg::TICK_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // column_addr[6:0], column_bits[22:7], zero[23]
	input  wire logic [1:0]  s_tuser,   // mode[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // column[6:0], pattern[22:7], zero[23]
	output logic      [0:0]  m_tuser    // pattern_valid[0]
);

	localparam int AW = $clog2(COLUMNS);

	// Input decode.
	logic                         acc;
	logic                         tick_en, pulse_en, wr_en, res_en;
	logic [pcs_pkg::ADDR_W-1:0]   in_addr;
	logic [pcs_pkg::BITS_W-1:0]   in_bits;
	pcs_pkg::pcs_col_t            nxt;

	// Stage 1: memory read in flight.
	logic                         s1_vld_q;
	pcs_pkg::pcs_col_t            col_s1;
	logic [pcs_pkg::BITS_W-1:0]   rd_data;

	// Output register.
	logic                         out_vld_q;
	logic [pcs_pkg::COL_W-1:0]    out_col_q;
	logic [pcs_pkg::BITS_W-1:0]   out_pat_q;
	logic                         out_hit_q;
	logic                         out_load;

	assign in_addr  = s_tdata[pcs_pkg::ADDR_W-1:0];
	assign in_bits  = s_tdata[pcs_pkg::ADDR_W +: pcs_pkg::BITS_W];

	// Load the output register when it is empty or being taken; stage 1 drains
	// into it, so a new word may enter whenever stage 1 moves.
	assign out_load = !out_vld_q || m_tready;
	assign s_tready = !s1_vld_q || out_load;
	assign acc      = s_tvalid && s_tready;

	assign tick_en  = acc && (s_tuser == pcs_pkg::MODE_TICK);
	assign pulse_en = acc && (s_tuser == pcs_pkg::MODE_PULSE);
	assign wr_en    = acc && (s_tuser == pcs_pkg::MODE_WRITE);
	assign res_en   = tick_en || pulse_en;

	pcs_timer #(
		.COLUMNS    (COLUMNS),
		.TICK_WIDTH (TICK_WIDTH)
	) u_timer (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick_en  (tick_en),
		.pulse_en (pulse_en),
		.nxt      (nxt)
	);

	// Read only for columns inside the image; the read data then holds while
	// stage 1 is stalled, since no new result word can enter.
	pcs_image_mem #(
		.COLUMNS (COLUMNS)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (in_addr),
		.wr_data (in_bits),
		.rd_en   (res_en && nxt.hit),
		.rd_addr (nxt.col[AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (s_tready) begin
			s1_vld_q <= res_en;
		end
	end

	always_ff @(posedge clk) begin
		if (res_en) begin
			col_s1 <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= s1_vld_q;
		end
	end

	// Blank the word when the period is unknown or the column is past the image.
	always_ff @(posedge clk) begin
		if (out_load && s1_vld_q) begin
			out_hit_q <= col_s1.hit;
			out_col_q <= col_s1.hit ? col_s1.col[pcs_pkg::COL_W-1:0] : '0;
			out_pat_q <= col_s1.hit ? rd_data : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_pat_q, out_col_q};
	assign m_tuser  = out_hit_q;

`ifndef SYNTHESIS
	a_blank_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && !out_hit_q |-> (out_col_q == '0) && (out_pat_q == '0))
		else $error("invalid output word is not blank");

	a_hit_inside_image: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_q && col_s1.hit |-> (32'(col_s1.col) < COLUMNS))
		else $error("hit column past the image");

	a_result_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		res_en |=> s1_vld_q)
		else $error("accepted tick or pulse lost before stage 1");

	a_pulse_col_zero: assert property (@(posedge clk) disable iff (!arst_n)
		pulse_en |-> nxt.col == '0)
		else $error("index pulse did not restart at column zero");
`endif

endmodule

`default_nettype wire

@@ design/pcs_timer.sv @@
// Rotation timing counters: elapsed ticks, ticks per column, column position.
// Depends on pcs_pkg.
`default_nettype none

module pcs_timer #(
	parameter int COLUMNS    = pcs_pkg::COLUMNS_DEF,
	parameter int TICK_WIDTH = pcs_pkg::TICK_WIDTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      tick_en,
	input  wire logic      pulse_en,
	output pcs_pkg::pcs_col_t nxt
);

	localparam int RW = $clog2(COLUMNS);

	logic [TICK_WIDTH-1:0]     elapsed_q, elapsed_d;
	logic [RW-1:0]             rem_q, rem_d;
	logic [pcs_pkg::TPC_W-1:0] quo_q, quo_d;
	logic [pcs_pkg::TPC_W-1:0] tpc_q, tpc_d;
	logic [pcs_pkg::TPC_W-1:0] sub_q, sub_d, sub_inc;
	logic [pcs_pkg::CNT_W-1:0] col_q, col_d;
	logic                      el_inc;

	assign el_inc  = elapsed_q != {TICK_WIDTH{1'b1}};
	assign sub_inc = sub_q + pcs_pkg::TPC_W'(1);

	always_comb begin
		elapsed_d = elapsed_q;
		rem_d     = rem_q;
		quo_d     = quo_q;
		tpc_d     = tpc_q;
		sub_d     = sub_q;
		col_d     = col_q;
		if (tick_en && el_inc) begin
			elapsed_d = elapsed_q + TICK_WIDTH'(1);
			// Track elapsed / COLUMNS with a wrapping remainder.
			if (rem_q == RW'(COLUMNS - 1)) begin
				rem_d = '0;
				if (quo_q != pcs_pkg::TPC_MAX) begin
					quo_d = quo_q + pcs_pkg::TPC_W'(1);
				end
			end else begin
				rem_d = rem_q + RW'(1);
			end
			// Track elapsed / ticks_per_column the same way.
			if (tpc_q != '0) begin
				if (sub_inc == tpc_q) begin
					sub_d = '0;
					if (col_q != pcs_pkg::CNT_W'(COLUMNS)) begin
						col_d = col_q + pcs_pkg::CNT_W'(1);
					end
				end else begin
					sub_d = sub_inc;
				end
			end
		end
		if (pulse_en) begin
			tpc_d     = quo_q;
			elapsed_d = '0;
			rem_d     = '0;
			quo_d     = '0;
			sub_d     = '0;
			col_d     = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
			tpc_q     <= '0;
			sub_q     <= '0;
			col_q     <= '0;
		end else begin
			elapsed_q <= elapsed_d;
			rem_q     <= rem_d;
			quo_q     <= quo_d;
			tpc_q     <= tpc_d;
			sub_q     <= sub_d;
			col_q     <= col_d;
		end
	end

	assign nxt.col = col_d;
	assign nxt.hit = (tpc_d != '0) && (col_d < pcs_pkg::CNT_W'(COLUMNS));

endmodule

`default_nettype wire

@@ design/pcs_image_mem.sv @@
// Column image memory: one write port, one registered read port, per-entry valid bits.
// Depends on pcs_pkg.
`default_nettype none

module pcs_image_mem #(
	parameter int COLUMNS = pcs_pkg::COLUMNS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr_en,
	input  wire logic [pcs_pkg::ADDR_W-1:0]  wr_addr,
	input  wire logic [pcs_pkg::BITS_W-1:0]  wr_data,
	input  wire logic                        rd_en,
	input  wire logic [$clog2(COLUMNS)-1:0]  rd_addr,
	output logic      [pcs_pkg::BITS_W-1:0]  rd_data
);

	localparam int AW = $clog2(COLUMNS);

	logic [pcs_pkg::BITS_W-1:0] mem [COLUMNS];
	logic [COLUMNS-1:0]         vld_q;
	logic [pcs_pkg::BITS_W-1:0] rd_mem_q;
	logic                       rd_vld_q;
	logic                       wr_ok;
	logic [AW-1:0]              wr_idx;

	// Drop writes past the last column.
	assign wr_ok  = wr_en && (32'(wr_addr) < COLUMNS);
	assign wr_idx = AW'(wr_addr);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_mem_q <= mem[rd_addr];
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	// A column never written reads as blank.
	assign rd_data = rd_vld_q ? rd_mem_q : '0;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for pov_column_scheduler: directed rows, then random rotations with image writes.
// Each accepted output word is checked against an in-bench column timing predictor.
// Depends on pcs_pkg and the pov_column_scheduler RTL.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [pcs_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
	localparam int                NCOL        = pcs_pkg::COLUMNS_DEF;
	localparam logic [15:0]       TICK_TOP    = 16'hFFFF;
	localparam int                TAIL_WORDS  = 650;
	localparam int                RAND_WORDS  = 800;

	typedef struct packed {
		logic [pcs_pkg::COL_W-1:0]  column;
		logic [pcs_pkg::BITS_W-1:0] pattern;
		logic                       valid;
	} col_result_t;

	localparam col_result_t BLANK = '0;

	typedef struct {
		logic [pcs_pkg::MODE_W-1:0] mode;
		logic [pcs_pkg::ADDR_W-1:0] addr;
		logic [pcs_pkg::BITS_W-1:0] bits;
		int                         reps;
		bit                         fixed;
		col_result_t                want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic [0:0]  m_tuser;

	// Predictor state: tick count since the last pulse, latched column period, image copy.
	logic [15:0]                elapsed_seen;
	logic [pcs_pkg::TPC_W-1:0]  period_seen;
	logic [pcs_pkg::BITS_W-1:0] image_seen [NCOL];

	col_result_t columns_due [$];
	stim_row_t   script [$];
	int          errors;
	int          words_done;
	int          words_sent;
	int          idle_pct;
	bit          tail_calm;

	pov_column_scheduler i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Column shown for the current count; blank while the period is unknown or past the image.
	function automatic col_result_t column_now();
		col_result_t r;
		logic [15:0] col;
		r = BLANK;
		if (period_seen != 0) begin
			col = elapsed_seen / period_seen;
			if (col < NCOL) begin
				r.column  = col[pcs_pkg::COL_W-1:0];
				r.pattern = image_seen[col];
				r.valid   = 1'b1;
			end
		end
		return r;
	endfunction

	// Advance the predictor by one accepted word and queue the column it shows.
	function automatic void schedule_word(input logic [pcs_pkg::MODE_W-1:0] mode,
			input logic [pcs_pkg::ADDR_W-1:0] addr, input logic [pcs_pkg::BITS_W-1:0] bits,
			input bit fixed, input col_result_t want);
		int q;
		case (mode)
			pcs_pkg::MODE_TICK: begin
				if (elapsed_seen != TICK_TOP)
					elapsed_seen++;
				columns_due.push_back(fixed ? want : column_now());
				words_done++;
			end
			pcs_pkg::MODE_PULSE: begin
				q           = elapsed_seen / NCOL;
				period_seen = (q > pcs_pkg::TPC_MAX) ? pcs_pkg::TPC_MAX
					: q[pcs_pkg::TPC_W-1:0];
				elapsed_seen = '0;
				columns_due.push_back(fixed ? want : column_now());
				words_done++;
			end
			pcs_pkg::MODE_WRITE: begin
				if (addr < NCOL) begin
					image_seen[addr] = bits;
					words_done++;
				end
			end
			default: ;
		endcase
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_word(input logic [pcs_pkg::MODE_W-1:0] mode,
			input logic [pcs_pkg::ADDR_W-1:0] addr,
			input logic [pcs_pkg::BITS_W-1:0] bits, input bit fixed = 1'b0,
			input col_result_t want = BLANK);
		if (words_sent % 40 == 0) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 10;
				default: idle_pct = 35;
			endcase
		end
		if (tail_calm)
			idle_pct = 0;
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {1'b0, bits, addr};
		do
			@(posedge clk);
		while (!s_tready);
		schedule_word(mode, addr, bits, fixed, want);
		words_sent++;
		@(negedge clk);
	endtask

	function automatic void add_row(input logic [pcs_pkg::MODE_W-1:0] mode,
			input logic [pcs_pkg::ADDR_W-1:0] addr,
			input logic [pcs_pkg::BITS_W-1:0] bits, input int reps, input bit fixed = 1'b0,
			input col_result_t want = BLANK);
		stim_row_t row;
		row.mode  = mode;
		row.addr  = addr;
		row.bits  = bits;
		row.reps  = reps;
		row.fixed = fixed;
		row.want  = want;
		script.push_back(row);
	endfunction

	// Output side: stall in random bursts; no new burst starts during the calm tail.
	initial begin : sink
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!tail_calm && $urandom_range(0, 99) < idle_pct) begin
				m_tready   <= 1'b0;
				stall_left = $urandom_range(1, 6) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted word with the oldest pending column.
	always @(posedge clk) begin : check_out
		col_result_t got;
		col_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got.column  = m_tdata[6:0];
			got.pattern = m_tdata[22:7];
			got.valid   = m_tuser[0];
			if (columns_due.size() == 0) begin
				errors++;
				$display("%0t unexpected word: column %0d pattern %h valid %0d",
					$time, got.column, got.pattern, got.valid);
			end else begin
				want = columns_due.pop_front();
				if (got.column != want.column) begin
					errors++;
					$display("%0t column: expected %0d actual %0d",
						$time, want.column, got.column);
				end
				if (got.pattern != want.pattern) begin
					errors++;
					$display("%0t pattern: expected %h actual %h",
						$time, want.pattern, got.pattern);
				end
				if (got.valid != want.valid) begin
					errors++;
					$display("%0t pattern_valid: expected %0d actual %0d",
						$time, want.valid, got.valid);
				end
			end
		end
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int ticks_n;
		int guard;
		logic [pcs_pkg::ADDR_W-1:0] wr_addr;
		clk          = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		m_tready     = 1'b0;
		errors       = 0;
		words_done   = 0;
		words_sent   = 0;
		idle_pct     = 0;
		tail_calm    = 1'b0;
		elapsed_seen = '0;
		period_seen  = '0;
		for (int i = 0; i < NCOL; i++)
			image_seen[i] = '0;

		// Directed rows: blank output before a period is known, image corners, address
		// past the image, unused mode, one full rotation at one tick per column, the
		// column past the last, and a later rotation that runs past the image.
		add_row(pcs_pkg::MODE_TICK,  7'd0,   16'h0000, 1,   1'b1, BLANK);
		add_row(pcs_pkg::MODE_PULSE, 7'd0,   16'h0000, 1,   1'b1, BLANK);
		add_row(pcs_pkg::MODE_WRITE, 7'd0,   16'hFFFF, 1);
		add_row(pcs_pkg::MODE_WRITE, 7'd119, 16'h8001, 1);
		add_row(pcs_pkg::MODE_WRITE, 7'd1,   16'hAAAA, 1);
		add_row(pcs_pkg::MODE_WRITE, 7'd2,   16'h5555, 1);
		add_row(pcs_pkg::MODE_WRITE, 7'd120, 16'h1234, 1);
		add_row(pcs_pkg::MODE_WRITE, 7'd127, 16'hFFFF, 1);
		add_row(MODE_UNUSED,         7'd127, 16'hFFFF, 1);
		add_row(pcs_pkg::MODE_TICK,  7'd0,   16'h0000, 239);
		add_row(pcs_pkg::MODE_PULSE, 7'd0,   16'h0000, 1,   1'b1, {7'd0, 16'hFFFF, 1'b1});
		add_row(pcs_pkg::MODE_TICK,  7'd0,   16'h0000, 119);
		add_row(pcs_pkg::MODE_TICK,  7'd0,   16'h0000, 1,   1'b1, BLANK);
		add_row(pcs_pkg::MODE_WRITE, 7'd119, 16'h0000, 1);
		add_row(pcs_pkg::MODE_PULSE, 7'd0,   16'h0000, 1);
		add_row(MODE_UNUSED,         7'd0,   16'h0000, 1);
		add_row(pcs_pkg::MODE_TICK,  7'd0,   16'h0000, 150);
		add_row(pcs_pkg::MODE_PULSE, 7'd0,   16'h0000, 1);
		add_row(pcs_pkg::MODE_TICK,  7'd0,   16'h0000, 10);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (script[r])
			for (int k = 0; k < script[r].reps; k++)
				send_word(script[r].mode, script[r].addr, script[r].bits,
					script[r].fixed, script[r].want);

		// Random rotations: a run of ticks with image writes and noise mixed in, then a
		// pulse. Most runs are long enough to latch a period; a few end early.
		words_done = 0;
		while (words_done < RAND_WORDS) begin
			ticks_n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 119)
				: $urandom_range(120, 480);
			for (int k = 0; k < ticks_n && words_done < RAND_WORDS; k++) begin
				if ($urandom_range(0, 11) == 0) begin
					wr_addr = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 127)
						: $urandom_range(0, 119);
					send_word(pcs_pkg::MODE_WRITE, wr_addr, $urandom_range(0, 16'hFFFF));
				end
				if ($urandom_range(0, 39) == 0)
					send_word(MODE_UNUSED, $urandom_range(0, 127),
						$urandom_range(0, 16'hFFFF));
				send_word(pcs_pkg::MODE_TICK, $urandom_range(0, 127),
					$urandom_range(0, 16'hFFFF));
				tail_calm = (words_done >= TAIL_WORDS);
			end
			send_word(pcs_pkg::MODE_PULSE, $urandom_range(0, 127),
				$urandom_range(0, 16'hFFFF));
			tail_calm = (words_done >= TAIL_WORDS);
		end
		s_tvalid <= 1'b0;

		// Drain: wait out the pending columns, then the read and output stages.
		guard = 0;
		while (columns_due.size() != 0 && guard < 2000) begin
			@(posedge clk);
			guard++;
		end
		repeat (8) @(posedge clk);
		if (columns_due.size() != 0)
			$display("%0t %0d expected words never arrived", $time, columns_due.size());
		if (errors == 0 && columns_due.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

@@ sim.f @@
design/pcs_pkg.sv
design/pcs_timer.sv
design/pcs_image_mem.sv
design/pov_column_scheduler.sv
sim/tb.sv
